// ----- design/filtered_pid_with_angle_wrap_defines.svh -----
// Assertion macros used by the checker file.
`ifndef FILTERED_PID_WITH_ANGLE_WRAP_DEFINES_SVH
`define FILTERED_PID_WITH_ANGLE_WRAP_DEFINES_SVH

// same-cycle implication
`define FPAW_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpaw check failed");

// next-cycle implication
`define FPAW_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpaw check failed");

`endif

// ----- design/fpaw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fpaw_pkg;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 32;
   localparam int SP_W     = 33;
   localparam int LIM_W    = 31;
   localparam int MEAS_W   = 24;
   localparam int ERR_W    = 35;
   localparam int PREV_W   = 40;
   localparam int DIFF_W   = 41;
   localparam int SUM_W    = 48;
   localparam int DIV_W    = 44;
   localparam int ACC_W    = 82;
   localparam int DRIVE_W  = 32;

   localparam int DIV_STEPS = DIV_W;
   localparam int MUL_STEPS = GAIN_W;

   // floor division of a signed value by ten is done on value + 10 * 2^40
   localparam logic [DIV_W-1:0] DIV_BIAS  = 44'hA00_0000_0000;
   localparam logic [DIV_W-1:0] ROUND_ADD = 44'd5;
   localparam logic [4:0]       DIVISOR   = 5'd10;

   localparam logic [SAMPLE_W-1:0] FOLD_THRESH   = 16'd260;
   localparam logic [SAMPLE_W-1:0] UNWRAP_THRESH = 16'd80;
   localparam logic [MEAS_W-1:0]   FULL_TURN     = 24'd360;

   localparam logic [1:0] MODE_FOLD   = 2'd0;
   localparam logic [1:0] MODE_PLAIN  = 2'd1;
   localparam logic [1:0] MODE_UNWRAP = 2'd2;
   localparam logic [1:0] MODE_SCALED = 2'd3;

   localparam logic [2:0] CSR_GAIN_P       = 3'd0;
   localparam logic [2:0] CSR_GAIN_I       = 3'd1;
   localparam logic [2:0] CSR_GAIN_D       = 3'd2;
   localparam logic [2:0] CSR_SETPOINT     = 3'd3;
   localparam logic [2:0] CSR_LIMIT        = 3'd4;
   localparam logic [2:0] CSR_LIMIT_SCALED = 3'd5;

   localparam logic [LIM_W-1:0] LIMIT_RESET        = 31'd12800;
   localparam logic [LIM_W-1:0] LIMIT_SCALED_RESET = 31'd25600;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_PREP,
      ST_DIV,
      ST_SUM,
      ST_MUL,
      ST_ADD,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic start;
   } mul_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage
`default_nettype wire

// ----- design/fpaw_smul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fpaw_smul (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire fpaw_pkg::mul_ctrl_type                 ctrl,
   input  wire logic signed [fpaw_pkg::PREV_W-1:0]     op_f,
   input  wire logic signed [fpaw_pkg::SUM_W-1:0]      op_s,
   input  wire logic signed [fpaw_pkg::DIFF_W-1:0]     op_d,
   input  wire logic signed [fpaw_pkg::GAIN_W-1:0]     gain_p,
   input  wire logic signed [fpaw_pkg::GAIN_W-1:0]     gain_i,
   input  wire logic signed [fpaw_pkg::GAIN_W-1:0]     gain_d,
   output fpaw_pkg::mul_status_type                    status,
   output logic signed [fpaw_pkg::ACC_W-1:0]           prod_p,
   output logic signed [fpaw_pkg::ACC_W-1:0]           prod_i,
   output logic signed [fpaw_pkg::ACC_W-1:0]           prod_d
);

   localparam int AW = fpaw_pkg::ACC_W;
   localparam int CW = $clog2(fpaw_pkg::MUL_STEPS);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic            first_ff, first_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [fpaw_pkg::GAIN_W-1:0] gp_ff, gp_in, gi_ff, gi_in, gd_ff, gd_in;
   logic [AW-1:0]   acc_p_ff, acc_p_in, acc_i_ff, acc_i_in, acc_d_ff, acc_d_in;
   logic [AW-1:0]   ext_f, ext_s, ext_d;
   logic [AW-1:0]   add_p, add_i, add_d;

   assign ext_f = {{(AW-fpaw_pkg::PREV_W){op_f[fpaw_pkg::PREV_W-1]}}, op_f};
   assign ext_s = {{(AW-fpaw_pkg::SUM_W){op_s[fpaw_pkg::SUM_W-1]}}, op_s};
   assign ext_d = {{(AW-fpaw_pkg::DIFF_W){op_d[fpaw_pkg::DIFF_W-1]}}, op_d};

   // MSB-first Horner over gain bits; the sign bit weighs negative
   always_comb begin
      add_p = '0;
      add_i = '0;
      add_d = '0;
      if (gp_ff[fpaw_pkg::GAIN_W-1]) add_p = first_ff ? (~ext_f + 1'b1) : ext_f;
      if (gi_ff[fpaw_pkg::GAIN_W-1]) add_i = first_ff ? (~ext_s + 1'b1) : ext_s;
      if (gd_ff[fpaw_pkg::GAIN_W-1]) add_d = first_ff ? (~ext_d + 1'b1) : ext_d;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      first_in = first_ff;
      cnt_in   = cnt_ff;
      gp_in    = gp_ff;
      gi_in    = gi_ff;
      gd_in    = gd_ff;
      acc_p_in = acc_p_ff;
      acc_i_in = acc_i_ff;
      acc_d_in = acc_d_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         cnt_in   = CW'(fpaw_pkg::MUL_STEPS - 1);
         gp_in    = gain_p;
         gi_in    = gain_i;
         gd_in    = gain_d;
         acc_p_in = '0;
         acc_i_in = '0;
         acc_d_in = '0;
      end else if (busy_ff) begin
         first_in = 1'b0;
         cnt_in   = cnt_ff - 1'b1;
         gp_in    = {gp_ff[fpaw_pkg::GAIN_W-2:0], 1'b0};
         gi_in    = {gi_ff[fpaw_pkg::GAIN_W-2:0], 1'b0};
         gd_in    = {gd_ff[fpaw_pkg::GAIN_W-2:0], 1'b0};
         acc_p_in = {acc_p_ff[AW-2:0], 1'b0} + add_p;
         acc_i_in = {acc_i_ff[AW-2:0], 1'b0} + add_i;
         acc_d_in = {acc_d_ff[AW-2:0], 1'b0} + add_d;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         first_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         first_ff <= first_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      gp_ff    <= gp_in;
      gi_ff    <= gi_in;
      gd_ff    <= gd_in;
      acc_p_ff <= acc_p_in;
      acc_i_ff <= acc_i_in;
      acc_d_ff <= acc_d_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign prod_p = $signed(acc_p_ff);
   assign prod_i = $signed(acc_i_ff);
   assign prod_d = $signed(acc_d_ff);

endmodule
`default_nettype wire

// ----- design/filtered_pid_with_angle_wrap.sv -----
// Filtered PID step, one result per input transfer.
// The result path runs through the 44-step bit-serial divide by ten and the
// 32-step bit-serial gain multiply.
// One input at a time: the next input is taken as soon as the
// result sits in the output register.
// Reset (synchronous): gains and setpoint 0, limits 50.0 and 100.0, filter state 0.
`timescale 1ns / 1ps
`default_nettype none
module filtered_pid_with_angle_wrap (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [1:0]                             req_mode,
   input  wire logic [fpaw_pkg::SAMPLE_W-1:0]          req_sample,
   input  wire logic                                   req_clear_integral,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [fpaw_pkg::DRIVE_W-1:0]         rsp_drive,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [2:0]                             csr_index,
   input  wire logic [fpaw_pkg::SP_W-1:0]              csr_data
);

   localparam int DCW = $clog2(fpaw_pkg::DIV_STEPS);

   fpaw_pkg::state_type state_ff, state_in;

   logic signed [fpaw_pkg::GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [fpaw_pkg::SP_W-1:0]   setpoint_ff;
   logic [fpaw_pkg::LIM_W-1:0]         limit_ff, limit_scaled_ff;

   logic [1:0]                         mode_ff;
   logic [fpaw_pkg::SAMPLE_W-1:0]      sample_ff;
   logic                               clr_ff;
   logic signed [fpaw_pkg::ERR_W-1:0]  err_ff, err_in;
   logic [fpaw_pkg::DIV_W-1:0]         div_ff, div_in;
   logic [3:0]                         rem_ff, rem_in;
   logic [DCW-1:0]                     div_cnt_ff, div_cnt_in;
   logic signed [fpaw_pkg::PREV_W-1:0] prev_ff, prev_in;
   logic signed [fpaw_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic signed [fpaw_pkg::SUM_W-1:0]  sop_ff, sop_in;
   logic signed [fpaw_pkg::DIFF_W-1:0] dop_ff, dop_in;
   logic signed [fpaw_pkg::ACC_W-1:0]  tot_ff, tot_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [fpaw_pkg::DRIVE_W-1:0] drive_ff, drive_in;

   logic signed [fpaw_pkg::MEAS_W-1:0] meas;
   logic signed [fpaw_pkg::ERR_W-1:0]  meas_q8, sp_ext;
   logic [fpaw_pkg::DIV_W-1:0]         e44, p44;
   logic [4:0]                         trial;
   logic                               trial_ge;
   logic signed [fpaw_pkg::PREV_W-1:0] filt;
   logic signed [fpaw_pkg::SUM_W:0]    sum_wide;
   logic signed [fpaw_pkg::SUM_W-1:0]  sum_base;
   logic [fpaw_pkg::LIM_W-1:0]         lim;
   logic signed [fpaw_pkg::ACC_W-1:0]  fin;
   logic                               fin_ok, load_rsp;

   fpaw_pkg::mul_ctrl_type   mul_ctrl;
   fpaw_pkg::mul_status_type mul_status;
   logic signed [fpaw_pkg::ACC_W-1:0] prod_p, prod_i, prod_d;

   fpaw_smul u_smul (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mul_ctrl),
      .op_f   (filt),
      .op_s   (sop_ff),
      .op_d   (dop_ff),
      .gain_p (gain_p_ff),
      .gain_i (gain_i_ff),
      .gain_d (gain_d_ff),
      .status (mul_status),
      .prod_p (prod_p),
      .prod_i (prod_i),
      .prod_d (prod_d)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff       <= '0;
         gain_i_ff       <= '0;
         gain_d_ff       <= '0;
         setpoint_ff     <= '0;
         limit_ff        <= fpaw_pkg::LIMIT_RESET;
         limit_scaled_ff <= fpaw_pkg::LIMIT_SCALED_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fpaw_pkg::CSR_GAIN_P:       gain_p_ff <= $signed(csr_data[fpaw_pkg::GAIN_W-1:0]);
            fpaw_pkg::CSR_GAIN_I:       gain_i_ff <= $signed(csr_data[fpaw_pkg::GAIN_W-1:0]);
            fpaw_pkg::CSR_GAIN_D:       gain_d_ff <= $signed(csr_data[fpaw_pkg::GAIN_W-1:0]);
            fpaw_pkg::CSR_SETPOINT:     setpoint_ff <= $signed(csr_data);
            fpaw_pkg::CSR_LIMIT:        limit_ff <= csr_data[fpaw_pkg::LIM_W-1:0];
            fpaw_pkg::CSR_LIMIT_SCALED: limit_scaled_ff <= csr_data[fpaw_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // measurement conditioning
   always_comb begin
      case (mode_ff)
         fpaw_pkg::MODE_FOLD:
            meas = (sample_ff > fpaw_pkg::FOLD_THRESH)
                 ? $signed(fpaw_pkg::FULL_TURN - {8'b0, sample_ff})
                 : $signed({8'b0, sample_ff});
         fpaw_pkg::MODE_UNWRAP:
            meas = (sample_ff < fpaw_pkg::UNWRAP_THRESH)
                 ? $signed({8'b0, sample_ff} + fpaw_pkg::FULL_TURN)
                 : $signed({8'b0, sample_ff});
         fpaw_pkg::MODE_SCALED:
            meas = $signed({2'b0, sample_ff, 6'b0} + {3'b0, sample_ff, 5'b0}
                           + {6'b0, sample_ff, 2'b0});
         default:
            meas = $signed({8'b0, sample_ff});
      endcase
   end

   assign meas_q8 = $signed({{(fpaw_pkg::ERR_W-fpaw_pkg::MEAS_W-8){meas[fpaw_pkg::MEAS_W-1]}},
                             meas, 8'b0});
   assign sp_ext  = $signed({{(fpaw_pkg::ERR_W-fpaw_pkg::SP_W){setpoint_ff[fpaw_pkg::SP_W-1]}},
                             setpoint_ff});
   assign err_in  = (mode_ff == fpaw_pkg::MODE_SCALED) ? (meas_q8 - sp_ext) : (sp_ext - meas_q8);

   assign e44 = {{(fpaw_pkg::DIV_W-fpaw_pkg::ERR_W){err_ff[fpaw_pkg::ERR_W-1]}}, err_ff};
   assign p44 = {{(fpaw_pkg::DIV_W-fpaw_pkg::PREV_W){prev_ff[fpaw_pkg::PREV_W-1]}}, prev_ff};

   assign trial    = {rem_ff, div_ff[fpaw_pkg::DIV_W-1]};
   assign trial_ge = (trial >= fpaw_pkg::DIVISOR);

   // quotient minus 2^40 keeps the same low bits
   assign filt = $signed(div_ff[fpaw_pkg::PREV_W-1:0]);

   assign sum_base = clr_ff ? '0 : sum_ff;
   assign sum_wide = {sum_base[fpaw_pkg::SUM_W-1], sum_base}
                   + {{(fpaw_pkg::SUM_W+1-fpaw_pkg::PREV_W){filt[fpaw_pkg::PREV_W-1]}}, filt};
   assign lim = (mode_ff == fpaw_pkg::MODE_SCALED) ? limit_scaled_ff : limit_ff;

   assign fin    = tot_ff + prod_d;
   assign fin_ok = (fin[fpaw_pkg::ACC_W-1:39] == '0) || (&fin[fpaw_pkg::ACC_W-1:39]);
   assign load_rsp = (state_ff == fpaw_pkg::ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in       = state_ff;
      req_stall      = 1'b1;
      mul_ctrl.start = 1'b0;
      unique case (state_ff)
         fpaw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) state_in = fpaw_pkg::ST_ERR;
         end
         fpaw_pkg::ST_ERR:  state_in = fpaw_pkg::ST_PREP;
         fpaw_pkg::ST_PREP: state_in = fpaw_pkg::ST_DIV;
         fpaw_pkg::ST_DIV: begin
            if (div_cnt_ff == '0) state_in = fpaw_pkg::ST_SUM;
         end
         fpaw_pkg::ST_SUM: begin
            mul_ctrl.start = 1'b1;
            state_in = fpaw_pkg::ST_MUL;
         end
         fpaw_pkg::ST_MUL: begin
            if (mul_status.done && !mul_status.busy) state_in = fpaw_pkg::ST_ADD;
         end
         fpaw_pkg::ST_ADD:  state_in = fpaw_pkg::ST_FIN;
         fpaw_pkg::ST_FIN: begin
            if (load_rsp) state_in = fpaw_pkg::ST_IDLE;
         end
         default: state_in = fpaw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      div_in     = div_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      sop_in     = sop_ff;
      dop_in     = dop_ff;
      tot_in     = tot_ff;
      sum_in     = sum_ff;
      prev_in    = prev_ff;
      case (state_ff)
         fpaw_pkg::ST_PREP: begin
            div_in     = {e44[fpaw_pkg::DIV_W-4:0], 3'b0} + e44 + p44
                       + fpaw_pkg::ROUND_ADD + fpaw_pkg::DIV_BIAS;
            rem_in     = '0;
            div_cnt_in = DCW'(fpaw_pkg::DIV_STEPS - 1);
         end
         fpaw_pkg::ST_DIV: begin
            rem_in     = trial_ge ? 4'(trial - fpaw_pkg::DIVISOR) : trial[3:0];
            div_in     = {div_ff[fpaw_pkg::DIV_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff - 1'b1;
         end
         fpaw_pkg::ST_SUM: begin
            if (sum_wide[fpaw_pkg::SUM_W] != sum_wide[fpaw_pkg::SUM_W-1])
               sop_in = sum_wide[fpaw_pkg::SUM_W]
                      ? $signed({1'b1, {(fpaw_pkg::SUM_W-1){1'b0}}})
                      : $signed({1'b0, {(fpaw_pkg::SUM_W-1){1'b1}}});
            else
               sop_in = sum_wide[fpaw_pkg::SUM_W-1:0];
            dop_in = {filt[fpaw_pkg::PREV_W-1], filt} - {prev_ff[fpaw_pkg::PREV_W-1], prev_ff};
         end
         fpaw_pkg::ST_ADD: begin
            tot_in  = prod_p + prod_i;
            sum_in  = (sop_ff > $signed({{(fpaw_pkg::SUM_W-fpaw_pkg::LIM_W){1'b0}}, lim}))
                    ? '0 : sop_ff;
            prev_in = filt;
         end
         default: ;
      endcase
   end

   always_comb begin
      drive_in     = drive_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         if (fin_ok)
            drive_in = fin[39:8];
         else
            drive_in = fin[fpaw_pkg::ACC_W-1] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpaw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         sum_ff       <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         mode_ff   <= req_mode;
         sample_ff <= req_sample;
         clr_ff    <= req_clear_integral;
      end
      if (state_ff == fpaw_pkg::ST_ERR) err_ff <= err_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      sop_ff   <= sop_in;
      dop_ff   <= dop_in;
      tot_ff   <= tot_in;
      drive_ff <= drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

endmodule
`default_nettype wire

// ----- design/fpaw_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "filtered_pid_with_angle_wrap_defines.svh"
module fpaw_assertions (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [fpaw_pkg::DRIVE_W-1:0]        rsp_drive
);

   // a held result keeps its value
   `FPAW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive))

   // one item at a time: busy right after an input transfer
   `FPAW_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall && !$rose(rsp_valid))

   // a new result shows up only as the block goes idle
   `FPAW_ASSERT_NOW(a_rsp_at_idle, clock, reset, $rose(rsp_valid), !req_stall)

endmodule

bind filtered_pid_with_angle_wrap fpaw_assertions u_fpaw_checker (.*);
`default_nettype wire
